// File: src/csm_pkg.sv
// Shared constants, payload types and arithmetic step functions for the cone support mapping.
// Used by every module of the block; depends on nothing else.
package csm_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int SINE_BITS       = 16;
  localparam int REG_WIDTH       = 31;
  localparam int SINE_WIDTH      = 17;
  localparam int CFG_WIDTH       = 31;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int SQ_WIDTH        = 2 * COORD_WIDTH;
  localparam int REM_WIDTH       = COORD_WIDTH + 2;
  localparam int PROD_WIDTH      = COORD_WIDTH + REG_WIDTH;
  localparam int APEX_WIDTH      = COORD_WIDTH + SINE_WIDTH;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_WIDTH      = 2;
  localparam int QCOUNT_WIDTH    = QPTR_WIDTH + 1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_RADIUS = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SINE   = 2'd2,
    REG_MARGIN = 2'd3
  } cfg_index_t;

  function automatic logic [COORD_WIDTH-1:0] const_isqrt(input logic [SQ_WIDTH-1:0] q);
    logic [COORD_WIDTH-1:0] res;
    logic [COORD_WIDTH-1:0] cand;
    res = '0;
    for (int i = COORD_WIDTH - 1; i >= 0; i--) begin
      cand = res | (COORD_WIDTH'(1) << i);
      if (SQ_WIDTH'(cand) * SQ_WIDTH'(cand) <= q) begin
        res = cand;
      end
    end
    const_isqrt = res;
  endfunction

  // Length of the fallback direction (-1, -1, -1) in fixed point.
  localparam logic [COORD_WIDTH-1:0] DIAG_LEN =
    const_isqrt(SQ_WIDTH'(3) << (2 * FRAC_BITS));

  typedef struct packed {
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
  } cone_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
  } cone_out_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0]  radius;
    logic [REG_WIDTH-1:0]  height;
    logic [SINE_WIDTH-1:0] sine;
    logic [REG_WIDTH-1:0]  margin;
  } cfg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                   mode;
    logic [2:0]             neg;
    logic                   apex;
    logic [COORD_WIDTH-1:0] mag_x;
    logic [COORD_WIDTH-1:0] mag_y;
    logic [COORD_WIDTH-1:0] mag_z;
    logic [COORD_WIDTH-1:0] len;
    logic [COORD_WIDTH-1:0] len_xy;
  } cls_t;

  typedef struct packed {
    logic push;
    cls_t item;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cls_t item;
  } q_rd_t;

  typedef struct packed {
    logic [SQ_WIDTH-1:0]    rad;
    logic [REM_WIDTH-1:0]   rem;
    logic [COORD_WIDTH-1:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t                r;
    logic [REM_WIDTH-1:0] acc;
    logic [REM_WIDTH-1:0] trial;
    acc   = {s.rem[REM_WIDTH-3:0], s.rad[SQ_WIDTH-1 -: 2]};
    trial = {s.root, 2'b01};
    r.rad = {s.rad[SQ_WIDTH-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[COORD_WIDTH-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[COORD_WIDTH-2:0], 1'b0};
    end
    sqrt_step = r;
  endfunction

endpackage

// File: src/cone_support_mapping_core.sv
// Top level of the cone support mapping: configuration registers and the
// front, queue and back parts. Depends on csm_pkg, csm_front, csm_queue and csm_back.
//
// Returns the point of a Z-axis cone, centered at mid-height, that lies farthest along
// a query direction, optionally pushed out by the skin margin along the unit direction.
// All coordinates are signed Q16.16 and results saturate. One query is taken per clock
// while query_stall is low and one result leaves per clock while result_stall is low.
// The pipeline holds a bit-per-stage square root in the front part and a bit-per-stage
// divider in the back part. Results come out in query order. The user must write the
// configuration registers through cfg_write/cfg_index/cfg_data only while no query is
// in flight; the block itself does not enforce this.
module cone_support_mapping_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                query_valid,
  output logic                                query_stall,
  input  csm_pkg::cone_in_t                   query,
  output logic                                result_valid,
  input  logic                                result_stall,
  output csm_pkg::cone_out_t                  result,
  input  logic                                cfg_write,
  input  logic [csm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [csm_pkg::CFG_WIDTH-1:0]       cfg_data
);
  import csm_pkg::*;

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_ready;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius <= REG_WIDTH'(65536);
      cfg.height <= REG_WIDTH'(65536);
      cfg.sine   <= SINE_WIDTH'(46341);
      cfg.margin <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        REG_RADIUS: cfg.radius <= cfg_data[REG_WIDTH-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[REG_WIDTH-1:0];
        REG_SINE:   cfg.sine   <= cfg_data[SINE_WIDTH-1:0];
        REG_MARGIN: cfg.margin <= cfg_data[REG_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  csm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .query       (query),
    .sine        (cfg.sine),
    .q_ready     (q_ready),
    .q_wr        (q_wr)
  );

  csm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .q_rd    (q_rd),
    .pop     (pop)
  );

  csm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rd         (q_rd),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: src/csm_front.sv
// Front part: takes queries, forms the squared lengths, the two integer square roots
// and the apex test, and pushes classified items. Depends on csm_pkg.
module csm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             query_valid,
  output logic                             query_stall,
  input  csm_pkg::cone_in_t                query,
  input  logic [csm_pkg::SINE_WIDTH-1:0]   sine,
  input  logic                             q_ready,
  output csm_pkg::q_wr_t                   q_wr
);
  import csm_pkg::*;

  typedef struct packed {
    logic                   mode;
    logic [2:0]             neg;
    logic                   z_pos;
    logic [COORD_WIDTH-1:0] mag_x;
    logic [COORD_WIDTH-1:0] mag_y;
    logic [COORD_WIDTH-1:0] mag_z;
  } dir_t;

  typedef struct packed {
    dir_t  d;
    sqrt_t s_all;
    sqrt_t s_xy;
  } root_t;

  logic                   adv;
  logic                   v0, v1, v2, va, vt;
  dir_t                   d0, d1, d2, da;
  logic [SQ_WIDTH-1:0]    sq_x, sq_y, sq_z, sum_xy, sum_z;
  logic                   rv [COORD_WIDTH+1];
  root_t                  rp [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] len_a, len_xy_a;
  logic [APEX_WIDTH-1:0]  lim_a;
  cls_t                   tail;
  dir_t                   d_in;

  assign adv         = q_ready;
  assign query_stall = !adv;
  assign q_wr.push   = vt && adv;
  assign q_wr.item   = tail;

  always_comb begin
    d_in.mode   = query.mode;
    d_in.neg    = {query.dir_z[COORD_WIDTH-1], query.dir_y[COORD_WIDTH-1],
                   query.dir_x[COORD_WIDTH-1]};
    d_in.z_pos  = !query.dir_z[COORD_WIDTH-1] && (query.dir_z != '0);
    d_in.mag_x  = query.dir_x[COORD_WIDTH-1] ? $unsigned(-query.dir_x) : $unsigned(query.dir_x);
    d_in.mag_y  = query.dir_y[COORD_WIDTH-1] ? $unsigned(-query.dir_y) : $unsigned(query.dir_y);
    d_in.mag_z  = query.dir_z[COORD_WIDTH-1] ? $unsigned(-query.dir_z) : $unsigned(query.dir_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      rv[0] <= 1'b0;
    end else if (adv) begin
      v0    <= query_valid;
      v1    <= v0;
      v2    <= v1;
      rv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0           <= d_in;
      d1           <= d0;
      sq_x         <= SQ_WIDTH'(d0.mag_x * d0.mag_x);
      sq_y         <= SQ_WIDTH'(d0.mag_y * d0.mag_y);
      sq_z         <= SQ_WIDTH'(d0.mag_z * d0.mag_z);
      d2           <= d1;
      sum_xy       <= sq_x + sq_y;
      sum_z        <= sq_z;
      rp[0].d      <= d2;
      rp[0].s_all  <= '{rad: sum_xy + sum_z, rem: '0, root: '0};
      rp[0].s_xy   <= '{rad: sum_xy, rem: '0, root: '0};
    end
  end

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[k+1] <= 1'b0;
      end else if (adv) begin
        rv[k+1] <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rp[k+1].d     <= rp[k].d;
        rp[k+1].s_all <= sqrt_step(rp[k].s_all);
        rp[k+1].s_xy  <= sqrt_step(rp[k].s_xy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vt <= 1'b0;
    end else if (adv) begin
      va <= rv[COORD_WIDTH];
      vt <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da          <= rp[COORD_WIDTH].d;
      len_a       <= rp[COORD_WIDTH].s_all.root;
      len_xy_a    <= rp[COORD_WIDTH].s_xy.root;
      lim_a       <= APEX_WIDTH'(rp[COORD_WIDTH].s_all.root * sine);
      tail.mode   <= da.mode;
      tail.neg    <= da.neg;
      tail.apex   <= da.z_pos &&
                     (APEX_WIDTH'({da.mag_z, {SINE_BITS{1'b0}}}) > lim_a);
      tail.mag_x  <= da.mag_x;
      tail.mag_y  <= da.mag_y;
      tail.mag_z  <= da.mag_z;
      tail.len    <= len_a;
      tail.len_xy <= len_xy_a;
    end
  end

endmodule

// File: src/csm_queue.sv
// Short queue that decouples the front part from the back part.
// Depends on csm_pkg.
module csm_queue (
  input  logic           clk,
  input  logic           rst,
  input  csm_pkg::q_wr_t q_wr,
  output logic           q_ready,
  output csm_pkg::q_rd_t q_rd,
  input  logic           pop
);
  import csm_pkg::*;

  cls_t                    mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_WIDTH-1:0] count;

  assign q_ready    = count < QCOUNT_WIDTH'(QUEUE_DEPTH);
  assign q_rd.valid = count != '0;
  assign q_rd.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem[wr_ptr] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (q_wr.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !q_wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    !(q_wr.push && count == QCOUNT_WIDTH'(QUEUE_DEPTH)))
    else $error("Transfer into a full queue.");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("Transfer out of an empty queue.");
  assert property (@(posedge clk) disable iff (rst)
    (q_wr.push && !pop) |=> count == $past(count) + 1'b1)
    else $error("Queue fill count lost an item.");
`endif

endmodule

// File: src/csm_back.sv
// Back part: forms the rim and margin numerators, divides them in a pipelined
// restoring divider, then sums, saturates and registers the point. Depends on csm_pkg.
module csm_back (
  input  logic                clk,
  input  logic                rst,
  input  csm_pkg::q_rd_t      q_rd,
  output logic                pop,
  input  csm_pkg::cfg_t       cfg,
  output logic                result_valid,
  input  logic                result_stall,
  output csm_pkg::cone_out_t  result
);
  import csm_pkg::*;

  localparam int DIV_RX = 0;
  localparam int DIV_RY = 1;
  localparam int DIV_MX = 2;
  localparam int DIV_MY = 3;
  localparam int DIV_MZ = 4;
  localparam int NUM_DIV = 5;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] rem;
    logic [COORD_WIDTH-1:0] low;
    logic [COORD_WIDTH-1:0] quo;
  } div_t;

  typedef struct packed {
    logic                                  mode;
    logic                                  rim_on;
    logic                                  apex;
    logic [2:0]                            neg;
    logic [2:0]                            mneg;
    logic [COORD_WIDTH-1:0]                den_rim;
    logic [COORD_WIDTH-1:0]                den_m;
    logic [NUM_DIV-1:0][PROD_WIDTH-1:0]    num;
  } prod_t;

  typedef struct packed {
    logic                          mode;
    logic                          rim_on;
    logic                          apex;
    logic [2:0]                    neg;
    logic [2:0]                    mneg;
    logic [COORD_WIDTH-1:0]        den_rim;
    logic [COORD_WIDTH-1:0]        den_m;
    logic [NUM_DIV-1:0]            ovf;
    logic [NUM_DIV-1:0][$bits(div_t)-1:0] dv;
  } div_pipe_t;

  function automatic div_t div_step(input div_t s, input logic [COORD_WIDTH-1:0] den);
    div_t                 r;
    logic [COORD_WIDTH:0] acc;
    acc   = {s.rem, s.low[COORD_WIDTH-1]};
    r.low = {s.low[COORD_WIDTH-2:0], 1'b0};
    if (acc >= {1'b0, den}) begin
      r.rem = COORD_WIDTH'(acc - {1'b0, den});
      r.quo = {s.quo[COORD_WIDTH-2:0], 1'b1};
    end else begin
      r.rem = COORD_WIDTH'(acc);
      r.quo = {s.quo[COORD_WIDTH-2:0], 1'b0};
    end
    div_step = r;
  endfunction

  function automatic logic signed [COORD_WIDTH+2:0] apply_sign(input logic neg,
                                                               input logic ovf,
                                                               input logic [COORD_WIDTH-1:0] q);
    logic signed [COORD_WIDTH+2:0] s;
    s = $signed({2'b00, ovf, (ovf ? {COORD_WIDTH{1'b0}} : q)});
    apply_sign = neg ? -s : s;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clamp(input logic signed [COORD_WIDTH+2:0] v);
    if (v[COORD_WIDTH+2:COORD_WIDTH-1] == '0 || v[COORD_WIDTH+2:COORD_WIDTH-1] == '1) begin
      clamp = v[COORD_WIDTH-1:0];
    end else if (v[COORD_WIDTH+2]) begin
      clamp = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      clamp = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  logic                          adv;
  logic                          vb;
  prod_t                         pb;
  logic                          dvv [COORD_WIDTH+1];
  div_pipe_t                     dp [COORD_WIDTH+1];
  cls_t                          it;
  logic                          len_zero;
  logic                          rim_on;
  logic [PROD_WIDTH-1:0]         margin_one;
  div_pipe_t                     init;
  div_t                          init_d;
  div_pipe_t                     fin;
  div_t                          fin_d [NUM_DIV];
  logic signed [COORD_WIDTH+2:0] half_s;
  logic signed [COORD_WIDTH+2:0] x_val, y_val, z_val, z_m;
  logic [PROD_WIDTH-COORD_WIDTH-1:0] hi_part;

  assign adv = !(result_valid && result_stall);
  assign pop = adv && q_rd.valid;
  assign it  = q_rd.item;

  assign len_zero   = it.len == '0;
  assign rim_on     = !it.apex && (it.len_xy != '0);
  assign margin_one = PROD_WIDTH'(cfg.margin) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= q_rd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pb.mode         <= it.mode;
      pb.rim_on       <= rim_on;
      pb.apex         <= it.apex;
      pb.neg          <= it.neg;
      pb.mneg         <= len_zero ? 3'b111 : it.neg;
      pb.den_rim      <= rim_on ? it.len_xy : COORD_WIDTH'(1);
      pb.den_m        <= len_zero ? DIAG_LEN : it.len;
      pb.num[DIV_RX]  <= PROD_WIDTH'(it.mag_x * cfg.radius);
      pb.num[DIV_RY]  <= PROD_WIDTH'(it.mag_y * cfg.radius);
      pb.num[DIV_MX]  <= len_zero ? margin_one : PROD_WIDTH'(it.mag_x * cfg.margin);
      pb.num[DIV_MY]  <= len_zero ? margin_one : PROD_WIDTH'(it.mag_y * cfg.margin);
      pb.num[DIV_MZ]  <= len_zero ? margin_one : PROD_WIDTH'(it.mag_z * cfg.margin);
    end
  end

  always_comb begin
    init.mode    = pb.mode;
    init.rim_on  = pb.rim_on;
    init.apex    = pb.apex;
    init.neg     = pb.neg;
    init.mneg    = pb.mneg;
    init.den_rim = pb.den_rim;
    init.den_m   = pb.den_m;
    init.ovf     = '0;
    init.dv      = '0;
    hi_part      = '0;
    init_d       = '0;
    for (int i = 0; i < NUM_DIV; i++) begin
      hi_part     = pb.num[i][PROD_WIDTH-1:COORD_WIDTH];
      init.ovf[i] = COORD_WIDTH'(hi_part) >=
                    ((i == DIV_RX || i == DIV_RY) ? pb.den_rim : pb.den_m);
      init_d.rem  = init.ovf[i] ? '0 : COORD_WIDTH'(hi_part);
      init_d.low  = pb.num[i][COORD_WIDTH-1:0];
      init_d.quo  = '0;
      init.dv[i]  = init_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp[0] <= init;
    end
  end

  for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (adv) begin
        dvv[k+1] <= dvv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dp[k+1].mode       <= dp[k].mode;
        dp[k+1].rim_on     <= dp[k].rim_on;
        dp[k+1].apex       <= dp[k].apex;
        dp[k+1].neg        <= dp[k].neg;
        dp[k+1].mneg       <= dp[k].mneg;
        dp[k+1].den_rim    <= dp[k].den_rim;
        dp[k+1].den_m      <= dp[k].den_m;
        dp[k+1].ovf        <= dp[k].ovf;
        dp[k+1].dv[DIV_RX] <= div_step(div_t'(dp[k].dv[DIV_RX]), dp[k].den_rim);
        dp[k+1].dv[DIV_RY] <= div_step(div_t'(dp[k].dv[DIV_RY]), dp[k].den_rim);
        dp[k+1].dv[DIV_MX] <= div_step(div_t'(dp[k].dv[DIV_MX]), dp[k].den_m);
        dp[k+1].dv[DIV_MY] <= div_step(div_t'(dp[k].dv[DIV_MY]), dp[k].den_m);
        dp[k+1].dv[DIV_MZ] <= div_step(div_t'(dp[k].dv[DIV_MZ]), dp[k].den_m);
      end
    end
  end

  always_comb begin
    fin = dp[COORD_WIDTH];
    for (int i = 0; i < NUM_DIV; i++) begin
      fin_d[i] = div_t'(fin.dv[i]);
    end
    half_s = $signed((COORD_WIDTH+3)'(cfg.height >> 1));
    x_val  = (fin.rim_on ? apply_sign(fin.neg[0], fin.ovf[DIV_RX], fin_d[DIV_RX].quo) : '0) +
             (fin.mode ? apply_sign(fin.mneg[0], fin.ovf[DIV_MX], fin_d[DIV_MX].quo) : '0);
    y_val  = (fin.rim_on ? apply_sign(fin.neg[1], fin.ovf[DIV_RY], fin_d[DIV_RY].quo) : '0) +
             (fin.mode ? apply_sign(fin.mneg[1], fin.ovf[DIV_MY], fin_d[DIV_MY].quo) : '0);
    z_m    = fin.mode ? apply_sign(fin.mneg[2], fin.ovf[DIV_MZ], fin_d[DIV_MZ].quo) : '0;
    z_val  = (fin.apex ? half_s : -half_s) + z_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dvv[COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.point_x <= clamp(x_val);
      result.point_y <= clamp(y_val);
      result.point_z <= clamp(z_val);
    end
  end

endmodule
